/* hw/rtl/adsr_pkg.sv */
// ----------------------------------------------------------------------------
// ADSR envelope gain package
// Widths, register indexes, state types and control structs shared by the
// envelope gain core, its serial multiply/divide unit and its sample scalers.
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 24;
    localparam int GAIN_W   = 16;
    localparam int FRAC_W   = 12;

    // Product of a gain-wide operand and a time-wide operand.
    localparam int PROD_W = TIME_W + GAIN_W;
    // Serial step counter covers one gain bit per cycle.
    localparam int STEP_W = $clog2(GAIN_W);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (TIME_W > GAIN_W) ? TIME_W : GAIN_W;

    localparam logic [GAIN_W-1:0] UNITY       = GAIN_W'(2 ** FRAC_W);
    localparam logic [GAIN_W-1:0] SUSTAIN_RST = UNITY;
    localparam logic [TIME_W-1:0] NOTE_RST    = TIME_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ATTACK_LEN    = 3'd0,
        REG_DECAY_END     = 3'd1,
        REG_SUSTAIN_LEVEL = 3'd2,
        REG_RELEASE_LEN   = 3'd3,
        REG_NOTE_LEN      = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CT_IDLE,
        CT_SETUP,
        CT_GAIN,
        CT_SCALE
    } ctl_state_t;

    typedef enum logic [1:0] {
        GU_IDLE,
        GU_MUL,
        GU_DIV,
        GU_DONE
    } gu_state_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_RUN,
        SC_DONE
    } sc_state_t;

    typedef struct packed {
        logic              start;
        logic [GAIN_W-1:0] x;
        logic [TIME_W-1:0] y;
        logic [TIME_W-1:0] z;
    } gu_cmd_t;

    typedef struct packed {
        logic              done;
        logic [GAIN_W-1:0] quot;
    } gu_sts_t;

    typedef struct packed {
        logic              start;
        logic [GAIN_W-1:0] gain;
    } sc_cmd_t;

    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] result;
    } sc_sts_t;

endpackage

/* hw/rtl/adsr_if.sv */
// ----------------------------------------------------------------------------
// ADSR envelope gain channels
// Sample request, result request and configuration write channels.
// ----------------------------------------------------------------------------
interface adsr_in_if import adsr_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface adsr_out_if import adsr_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       note_done;

    modport source (output valid, output left_out, output right_out, output note_done,
                    input ready);
    modport sink (input valid, input left_out, input right_out, input note_done,
                  output ready);
endinterface

interface adsr_cfg_if import adsr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/adsr_muldiv.sv */
// ----------------------------------------------------------------------------
// ADSR serial multiply/divide unit
// Computes floor(x * y / z) for y < z, one bit per cycle: a shift-and-add
// multiply followed by a restoring divide in the same shift register.
// ----------------------------------------------------------------------------
module adsr_muldiv import adsr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  gu_cmd_t cmd,
    output gu_sts_t sts
);

    gu_state_t         state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [TIME_W-1:0] y_reg, y_next;
    logic [TIME_W-1:0] z_reg, z_next;

    logic [TIME_W:0]   mul_sum;
    logic [TIME_W+1:0] div_diff;
    logic              last_step;

    assign last_step = (step_reg == STEP_W'(GAIN_W - 1));

    // Multiply: the low half holds the remaining multiplier bits.
    assign mul_sum = {1'b0, acc_reg[PROD_W-1:GAIN_W]}
                   + (acc_reg[0] ? {1'b0, y_reg} : {(TIME_W+1){1'b0}});

    // Divide: the partial remainder sits in the high half and stays below z.
    assign div_diff = {1'b0, acc_reg[PROD_W-1:GAIN_W], acc_reg[GAIN_W-1]}
                    - {2'b00, z_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= GU_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        y_next     = y_reg;
        z_next     = z_reg;

        case (state_reg)
            GU_MUL:
            begin
                acc_next  = {mul_sum, acc_reg[GAIN_W-1:1]};
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    state_next = GU_DIV;
                    step_next  = '0;
                end
            end
            GU_DIV:
            begin
                if (!div_diff[TIME_W+1])
                begin
                    acc_next = {div_diff[TIME_W-1:0], acc_reg[GAIN_W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = {acc_reg[PROD_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    state_next = GU_DONE;
                    step_next  = '0;
                end
            end
            default:
            begin
            end
        endcase

        if (cmd.start)
        begin
            state_next = GU_MUL;
            step_next  = '0;
            acc_next   = {{TIME_W{1'b0}}, cmd.x};
            y_next     = cmd.y;
            z_next     = cmd.z;
        end
    end

    assign sts.done = (state_reg == GU_DONE);
    assign sts.quot = acc_reg[GAIN_W-1:0];

endmodule

/* hw/rtl/adsr_scaler.sv */
// ----------------------------------------------------------------------------
// ADSR sample scaler
// Multiplies a signed sample by an unsigned Q4.12 gain one gain bit per
// cycle, then rounds half up and saturates to the sample width.
// ----------------------------------------------------------------------------
module adsr_scaler import adsr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  sc_cmd_t                    cmd,
    input  logic signed [SAMPLE_W-1:0] sample,
    output sc_sts_t                    sts
);

    localparam int HI_W = SAMPLE_W + 2;
    localparam int P_W  = HI_W + GAIN_W;

    sc_state_t                  state_reg, state_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic [P_W-1:0]             acc_reg, acc_next;
    logic signed [SAMPLE_W-1:0] smp_reg, smp_next;

    logic signed [HI_W-1:0] hi_sum;
    logic signed [P_W-1:0]  rounded;
    logic signed [P_W-1:0]  shifted;
    logic                   overflow;

    assign hi_sum = $signed(acc_reg[P_W-1:GAIN_W])
                  + (acc_reg[0] ? HI_W'(smp_reg) : HI_W'(0));

    assign rounded = $signed(acc_reg) + P_W'(2 ** (FRAC_W - 1));
    assign shifted = rounded >>> FRAC_W;

    // Out of range unless every bit above the result's sign matches it.
    assign overflow = !((&shifted[P_W-1:SAMPLE_W-1]) || !(|shifted[P_W-1:SAMPLE_W-1]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        smp_reg <= smp_next;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        smp_next   = smp_reg;

        case (state_reg)
            SC_RUN:
            begin
                acc_next  = {hi_sum[HI_W-1], hi_sum, acc_reg[GAIN_W-1:1]};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(GAIN_W - 1))
                begin
                    state_next = SC_DONE;
                    step_next  = '0;
                end
            end
            default:
            begin
            end
        endcase

        if (cmd.start)
        begin
            state_next = SC_RUN;
            step_next  = '0;
            acc_next   = {{HI_W{1'b0}}, cmd.gain};
            smp_next   = sample;
        end
    end

    always_comb
    begin
        sts.done = (state_reg == SC_DONE);
        if (overflow)
        begin
            sts.result = shifted[P_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                        : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else
        begin
            sts.result = shifted[SAMPLE_W-1:0];
        end
    end

endmodule

/* hw/rtl/adsr_envelope_gain_core.sv */
// ----------------------------------------------------------------------------
// ADSR envelope gain core
// Applies a linear attack/decay/sustain/release gain to a stereo sample pair.
// ----------------------------------------------------------------------------
// Path: in attack, decay and release a request passes through the 16-step
// serial multiply, the 16-step serial divide and the 16-step sample scalers;
// in sustain only the scalers run.
// Flow: one request at a time is processed; a finished result waits in the
// output register while the next request is taken.
// Reset: the sample counter clears and the config registers take their reset values.
module adsr_envelope_gain_core import adsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    adsr_in_if.sink    samples,
    adsr_out_if.source results,
    adsr_cfg_if.sink   cfg
);

    logic [TIME_W-1:0] attack_len_reg;
    logic [TIME_W-1:0] decay_end_reg;
    logic [GAIN_W-1:0] sustain_level_reg;
    logic [TIME_W-1:0] release_len_reg;
    logic [TIME_W-1:0] note_len_reg;

    ctl_state_t        state_reg, state_next;
    logic [TIME_W-1:0] count_reg, count_next;
    logic              out_valid_reg, out_valid_next;

    logic [TIME_W-1:0]          t_reg, t_next;
    logic signed [SAMPLE_W-1:0] left_reg, left_next;
    logic signed [SAMPLE_W-1:0] right_reg, right_next;
    logic                       last_reg, last_next;
    logic                       decay_reg, decay_next;
    logic                       sub_reg, sub_next;

    logic signed [SAMPLE_W-1:0] left_out_reg, left_out_next;
    logic signed [SAMPLE_W-1:0] right_out_reg, right_out_next;
    logic                       note_done_reg, note_done_next;

    gu_cmd_t gu_cmd;
    gu_sts_t gu_sts;
    sc_cmd_t sc_cmd;
    sc_sts_t sc_left_sts;
    sc_sts_t sc_right_sts;

    logic              accept;
    logic [TIME_W:0]   count_inc;
    logic              t_lt_a;
    logic              t_lt_d;
    logic              in_release;
    logic [GAIN_W-1:0] gain_base;
    logic [GAIN_W-1:0] gain_final;

    assign accept    = samples.valid && samples.ready;
    assign count_inc = {1'b0, count_reg} + 1'b1;

    assign t_lt_a     = t_reg < attack_len_reg;
    assign t_lt_d     = t_reg < decay_end_reg;
    assign in_release = (release_len_reg != '0)
                     && (({1'b0, t_reg} + {1'b0, release_len_reg}) > {1'b0, note_len_reg});

    assign gain_base  = decay_reg ? UNITY : '0;
    assign gain_final = sub_reg ? (gain_base - gu_sts.quot) : (gain_base + gu_sts.quot);

    adsr_muldiv u_muldiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (gu_cmd),
        .sts   (gu_sts)
    );

    adsr_scaler u_scaler_left
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (sc_cmd),
        .sample (left_reg),
        .sts    (sc_left_sts)
    );

    adsr_scaler u_scaler_right
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (sc_cmd),
        .sample (right_reg),
        .sts    (sc_right_sts)
    );

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_len_reg    <= '0;
            decay_end_reg     <= '0;
            sustain_level_reg <= SUSTAIN_RST;
            release_len_reg   <= '0;
            note_len_reg      <= NOTE_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_ATTACK_LEN:    attack_len_reg    <= cfg.data[TIME_W-1:0];
                REG_DECAY_END:     decay_end_reg     <= cfg.data[TIME_W-1:0];
                REG_SUSTAIN_LEVEL: sustain_level_reg <= cfg.data[GAIN_W-1:0];
                REG_RELEASE_LEN:   release_len_reg   <= cfg.data[TIME_W-1:0];
                REG_NOTE_LEN:      note_len_reg      <= cfg.data[TIME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CT_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg         <= t_next;
        left_reg      <= left_next;
        right_reg     <= right_next;
        last_reg      <= last_next;
        decay_reg     <= decay_next;
        sub_reg       <= sub_next;
        left_out_reg  <= left_out_next;
        right_out_reg <= right_out_next;
        note_done_reg <= note_done_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        t_next         = t_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        last_next      = last_reg;
        decay_next     = decay_reg;
        sub_next       = sub_reg;
        left_out_next  = left_out_reg;
        right_out_next = right_out_reg;
        note_done_next = note_done_reg;
        out_valid_next = out_valid_reg && !results.ready;

        samples.ready  = 1'b0;
        gu_cmd         = '0;
        sc_cmd         = '0;

        case (state_reg)
            CT_IDLE:
            begin
                samples.ready = 1'b1;
                if (accept)
                begin
                    // The counter moves on at acceptance; the gain uses the old value.
                    t_next     = count_reg;
                    left_next  = samples.left_in;
                    right_next = samples.right_in;
                    last_next  = count_inc >= {1'b0, note_len_reg};
                    count_next = (count_inc >= {1'b0, note_len_reg}) ? '0
                                                                     : count_inc[TIME_W-1:0];
                    state_next = CT_SETUP;
                end
            end
            CT_SETUP:
            begin
                decay_next = 1'b0;
                sub_next   = 1'b0;
                if (t_lt_a)
                begin
                    gu_cmd.start = 1'b1;
                    gu_cmd.x     = UNITY;
                    gu_cmd.y     = t_reg;
                    gu_cmd.z     = attack_len_reg;
                    state_next   = CT_GAIN;
                end
                else if (t_lt_d)
                begin
                    gu_cmd.start = 1'b1;
                    gu_cmd.x     = (sustain_level_reg >= UNITY) ? (sustain_level_reg - UNITY)
                                                                : (UNITY - sustain_level_reg);
                    gu_cmd.y     = t_reg - attack_len_reg;
                    gu_cmd.z     = decay_end_reg - attack_len_reg;
                    decay_next   = 1'b1;
                    sub_next     = sustain_level_reg < UNITY;
                    state_next   = CT_GAIN;
                end
                else if (in_release)
                begin
                    // A zero sustain level releases from unity gain.
                    gu_cmd.start = 1'b1;
                    gu_cmd.x     = (sustain_level_reg == '0) ? UNITY : sustain_level_reg;
                    gu_cmd.y     = (note_len_reg > t_reg) ? (note_len_reg - t_reg) : '0;
                    gu_cmd.z     = release_len_reg;
                    state_next   = CT_GAIN;
                end
                else
                begin
                    sc_cmd.start = 1'b1;
                    sc_cmd.gain  = sustain_level_reg;
                    state_next   = CT_SCALE;
                end
            end
            CT_GAIN:
            begin
                if (gu_sts.done)
                begin
                    sc_cmd.start = 1'b1;
                    sc_cmd.gain  = gain_final;
                    state_next   = CT_SCALE;
                end
            end
            CT_SCALE:
            begin
                if (sc_left_sts.done && sc_right_sts.done
                    && (!out_valid_reg || results.ready))
                begin
                    left_out_next  = sc_left_sts.result;
                    right_out_next = sc_right_sts.result;
                    note_done_next = last_reg;
                    out_valid_next = 1'b1;
                    state_next     = CT_IDLE;
                end
            end
            default:
            begin
                state_next = CT_IDLE;
            end
        endcase
    end

    assign results.valid     = out_valid_reg;
    assign results.left_out  = left_out_reg;
    assign results.right_out = right_out_reg;
    assign results.note_done = note_done_reg;

endmodule
